@@ hdl/srt_pkg.sv @@
// Shared types, codes and constants of the static route table.
package srt_pkg;

   localparam int DEF_TABLE_DEPTH = 64;
   localparam int DEF_MAX_FLAG    = 7;

   localparam int IDX_W     = 6;
   localparam int FIELD_W   = 3;
   localparam int IP_W      = 32;
   localparam int FLAG_W    = 4;
   localparam int IFC_W     = 16;
   localparam int MET_W     = 16;
   localparam int CNT_OUT_W = 7;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_DELETE = 2'd1,
      OP_EDIT   = 2'd2,
      OP_LOOKUP = 2'd3
   } op_type;

   localparam logic [FIELD_W-1:0] FLD_DEST  = 3'd0;
   localparam logic [FIELD_W-1:0] FLD_MASK  = 3'd1;
   localparam logic [FIELD_W-1:0] FLD_GW    = 3'd2;
   localparam logic [FIELD_W-1:0] FLD_FLAG  = 3'd3;
   localparam logic [FIELD_W-1:0] FLD_IFC   = 3'd4;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_SHIFT,
      S_SCAN,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic [1:0]         operation;
      logic [IDX_W-1:0]   entry_index;
      logic [FIELD_W-1:0] edit_field;
      logic [IP_W-1:0]    destination;
      logic [IP_W-1:0]    subnet_mask;
      logic [IP_W-1:0]    gateway;
      logic [FLAG_W-1:0]  route_flag;
      logic [IFC_W-1:0]   interface_id;
      logic [MET_W-1:0]   metric;
      logic [IP_W-1:0]    edit_value;
   } req_type;

   typedef struct packed {
      logic                 ok;
      logic [IP_W-1:0]      out_destination;
      logic [IP_W-1:0]      out_mask;
      logic [IP_W-1:0]      out_gateway;
      logic [FLAG_W-1:0]    out_flag;
      logic [IFC_W-1:0]     out_interface;
      logic [MET_W-1:0]     out_metric;
      logic [CNT_OUT_W-1:0] route_count;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic start;
      logic add_write;
      logic edit_write;
      logic set_ok;
      logic shift;
      logic scan;
      logic count_inc;
      logic count_dec;
      logic take_hit;
      logic emit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] op;
      logic       add_ok;
      logic       idx_ok;
      logic       edit_ok;
      logic       count_zero;
      logic       shift_more;
      logic       scan_more;
      logic       pend;
      logic       hit;
      logic       rsp_free;
   } status_type;

endpackage

@@ hdl/static_route_table_first_match.sv @@
// Top level of the ordered IPv4 route table with first-match lookup.
//
//   channel  ports                            direction  beat
//   request  req_valid, req_stall, req_item   in         one operation
//   response rsp_valid, rsp_stall, rsp_item   out        one result per request
//
// One request is worked at a time. Add, edit, a refused delete and a lookup on
// an empty table go from decode straight to finish. Delete moves each route
// after the deleted index down one place; lookup scans from the first route
// until the first match, or through all routes with no match. The route
// memories have a single registered read port, and both walk the table through
// it one entry per cycle. A new request is taken as soon as the previous result
// sits in the output register, even while it is stalled.
// Reset clears the route count; the memories need no clearing and are ready
// in the first cycle after reset.
module static_route_table_first_match #(
   parameter int TABLE_DEPTH = srt_pkg::DEF_TABLE_DEPTH,
   parameter int MAX_FLAG    = srt_pkg::DEF_MAX_FLAG
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  srt_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output srt_pkg::rsp_type rsp_item
);

   import srt_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencing: accept, decode, shift or scan the table, hand off the result
   srt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // storage, compare and output register
   srt_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .MAX_FLAG    (MAX_FLAG)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule

@@ hdl/srt_ram.sv @@
// Generic simple dual-port RAM, one write port and one registered read port.
module srt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/srt_ctrl.sv @@
// Sequencing state machine of the route table: decode, shift, scan, finish.
module srt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  srt_pkg::status_type    status,
   output srt_pkg::cmd_type       cmd
);

   import srt_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (status.op)
               OP_DELETE: state_in = status.idx_ok ? S_SHIFT : S_FINISH;
               OP_LOOKUP: state_in = status.count_zero ? S_FINISH : S_SCAN;
               default:   state_in = S_FINISH;
            endcase
         end
         S_SHIFT: begin
            if (!status.shift_more && !status.pend) begin
               state_in = S_FINISH;
            end
         end
         S_SCAN: begin
            if (status.hit || (!status.scan_more && !status.pend)) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (status.rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         S_DECODE: begin
            cmd.start = 1'b1;
            case (status.op)
               OP_ADD: begin
                  cmd.add_write = status.add_ok;
                  cmd.count_inc = status.add_ok;
                  cmd.set_ok    = status.add_ok;
               end
               OP_DELETE: begin
                  cmd.set_ok = status.idx_ok;
               end
               OP_EDIT: begin
                  cmd.edit_write = status.idx_ok && status.edit_ok;
                  cmd.set_ok     = status.idx_ok && status.edit_ok;
               end
               default: begin
               end
            endcase
         end
         S_SHIFT: begin
            cmd.shift     = 1'b1;
            cmd.count_dec = !status.shift_more && !status.pend;
         end
         S_SCAN: begin
            // stop issuing reads once the first match is in hand
            cmd.scan     = !status.hit;
            cmd.take_hit = status.hit;
            cmd.set_ok   = status.hit;
         end
         S_FINISH: begin
            cmd.emit = status.rsp_free;
         end
         default: begin
         end
      endcase
   end

   a_hit_ends_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && status.hit) |=> (state_ff == S_FINISH))
      else $error("scan did not stop on the first match");

   a_table_ops_checked: assert property (@(posedge clock) disable iff (reset)
      (cmd.add_write |-> status.add_ok) and (cmd.edit_write |-> status.idx_ok))
      else $error("table written without a passing check");

endmodule

@@ hdl/srt_datapath.sv @@
// Route memories, count, scan pointer, match compare and result register.
module srt_datapath #(
   parameter int TABLE_DEPTH = srt_pkg::DEF_TABLE_DEPTH,
   parameter int MAX_FLAG    = srt_pkg::DEF_MAX_FLAG
) (
   input  logic                clock,
   input  logic                reset,
   input  srt_pkg::req_type    req_item,
   input  srt_pkg::cmd_type    cmd,
   output srt_pkg::status_type status,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output srt_pkg::rsp_type    rsp_item
);

   import srt_pkg::*;

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int XW = (CW > IDX_W) ? CW : IDX_W;
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

   req_type       req_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic          pend_ff, pend_in;
   logic          ok_ff, ok_in;
   rsp_type       found_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_item_ff, rsp_item_in;

   logic [XW-1:0] idx_x;
   logic [AW-1:0] idx_addr;
   logic [CW-1:0] ptr_plus, ptr_minus;
   logic          shift_more, scan_more, shift_write, all_we, edit_ok, hit;
   logic          is_lookup;

   logic [AW-1:0]     wr_addr, rd_addr;
   logic [IP_W-1:0]   dest_wd, mask_wd, gw_wd;
   logic [FLAG_W-1:0] flag_wd;
   logic [IFC_W-1:0]  ifc_wd;
   logic [MET_W-1:0]  met_wd;
   logic              dest_we, mask_we, gw_we, flag_we, ifc_we;
   logic [IP_W-1:0]   rd_dest, rd_mask, rd_gw;
   logic [FLAG_W-1:0] rd_flag;
   logic [IFC_W-1:0]  rd_ifc;
   logic [MET_W-1:0]  rd_met;

   assign idx_x      = XW'(req_ff.entry_index);
   assign idx_addr   = idx_x[AW-1:0];
   assign ptr_plus   = ptr_ff + CW'(1);
   assign ptr_minus  = ptr_ff - CW'(1);
   assign shift_more = ptr_plus < count_ff;
   assign scan_more  = ptr_ff < count_ff;
   assign shift_write = cmd.shift && pend_ff;
   assign all_we     = cmd.add_write || shift_write;
   assign hit        = pend_ff && (rd_dest == (req_ff.destination & rd_mask));
   assign is_lookup  = req_ff.operation == OP_LOOKUP;

   always_comb begin
      case (req_ff.edit_field)
         FLD_DEST, FLD_MASK, FLD_GW, FLD_IFC: edit_ok = 1'b1;
         FLD_FLAG: edit_ok = req_ff.edit_value[IFC_W-1:0] <= IFC_W'(MAX_FLAG);
         default:  edit_ok = 1'b0;
      endcase
   end

   // memory addressing and write data
   always_comb begin
      if (cmd.add_write) begin
         wr_addr = count_ff[AW-1:0];
      end else if (cmd.edit_write) begin
         wr_addr = idx_addr;
      end else begin
         wr_addr = ptr_minus[AW-1:0];
      end
      rd_addr = cmd.shift ? ptr_plus[AW-1:0] : ptr_ff[AW-1:0];

      dest_wd = shift_write ? rd_dest
              : (cmd.edit_write ? req_ff.edit_value : req_ff.destination);
      mask_wd = shift_write ? rd_mask
              : (cmd.edit_write ? req_ff.edit_value : req_ff.subnet_mask);
      gw_wd   = shift_write ? rd_gw
              : (cmd.edit_write ? req_ff.edit_value : req_ff.gateway);
      flag_wd = shift_write ? rd_flag
              : (cmd.edit_write ? req_ff.edit_value[FLAG_W-1:0] : req_ff.route_flag);
      ifc_wd  = shift_write ? rd_ifc
              : (cmd.edit_write ? req_ff.edit_value[IFC_W-1:0] : req_ff.interface_id);
      met_wd  = shift_write ? rd_met : req_ff.metric;

      dest_we = all_we || (cmd.edit_write && req_ff.edit_field == FLD_DEST);
      mask_we = all_we || (cmd.edit_write && req_ff.edit_field == FLD_MASK);
      gw_we   = all_we || (cmd.edit_write && req_ff.edit_field == FLD_GW);
      flag_we = all_we || (cmd.edit_write && req_ff.edit_field == FLD_FLAG);
      ifc_we  = all_we || (cmd.edit_write && req_ff.edit_field == FLD_IFC);
   end

   srt_ram #(.WIDTH(IP_W), .DEPTH(TABLE_DEPTH)) u_dest_ram (
      .clock(clock), .wr_en(dest_we), .wr_addr(wr_addr), .wr_data(dest_wd),
      .rd_addr(rd_addr), .rd_data(rd_dest));
   srt_ram #(.WIDTH(IP_W), .DEPTH(TABLE_DEPTH)) u_mask_ram (
      .clock(clock), .wr_en(mask_we), .wr_addr(wr_addr), .wr_data(mask_wd),
      .rd_addr(rd_addr), .rd_data(rd_mask));
   srt_ram #(.WIDTH(IP_W), .DEPTH(TABLE_DEPTH)) u_gw_ram (
      .clock(clock), .wr_en(gw_we), .wr_addr(wr_addr), .wr_data(gw_wd),
      .rd_addr(rd_addr), .rd_data(rd_gw));
   srt_ram #(.WIDTH(FLAG_W), .DEPTH(TABLE_DEPTH)) u_flag_ram (
      .clock(clock), .wr_en(flag_we), .wr_addr(wr_addr), .wr_data(flag_wd),
      .rd_addr(rd_addr), .rd_data(rd_flag));
   srt_ram #(.WIDTH(IFC_W), .DEPTH(TABLE_DEPTH)) u_ifc_ram (
      .clock(clock), .wr_en(ifc_we), .wr_addr(wr_addr), .wr_data(ifc_wd),
      .rd_addr(rd_addr), .rd_data(rd_ifc));
   srt_ram #(.WIDTH(MET_W), .DEPTH(TABLE_DEPTH)) u_met_ram (
      .clock(clock), .wr_en(all_we), .wr_addr(wr_addr), .wr_data(met_wd),
      .rd_addr(rd_addr), .rd_data(rd_met));

   // count, pointer and bookkeeping
   always_comb begin
      count_in = count_ff;
      if (cmd.count_inc) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.count_dec) begin
         count_in = count_ff - CW'(1);
      end

      ptr_in = ptr_ff;
      if (cmd.start) begin
         ptr_in = (req_ff.operation == OP_DELETE) ? idx_x[CW-1:0] : '0;
      end else if ((cmd.shift && shift_more) || (cmd.scan && scan_more)) begin
         ptr_in = ptr_plus;
      end

      pend_in = (cmd.shift && shift_more) || (cmd.scan && scan_more);

      ok_in = ok_ff;
      if (cmd.set_ok) begin
         ok_in = 1'b1;
      end else if (cmd.start) begin
         ok_in = 1'b0;
      end

      rsp_valid_in = cmd.emit || (rsp_valid_ff && rsp_stall);

      rsp_item_in = '0;
      if (ok_ff && is_lookup) begin
         rsp_item_in = found_ff;
      end
      rsp_item_in.ok          = ok_ff;
      rsp_item_in.route_count = CNT_OUT_W'(count_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ptr_ff       <= '0;
         pend_ff      <= 1'b0;
         ok_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         pend_ff      <= pend_in;
         ok_ff        <= ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_item;
      end
      if (cmd.take_hit) begin
         found_ff.ok              <= 1'b1;
         found_ff.out_destination <= rd_dest;
         found_ff.out_mask        <= rd_mask;
         found_ff.out_gateway     <= rd_gw;
         found_ff.out_flag        <= rd_flag;
         found_ff.out_interface   <= rd_ifc;
         found_ff.out_metric      <= rd_met;
         found_ff.route_count     <= '0;
      end
      if (cmd.emit) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   always_comb begin
      status.op         = req_ff.operation;
      status.add_ok     = (req_ff.route_flag != '0) && (count_ff < DEPTH_C);
      status.idx_ok     = idx_x < XW'(count_ff);
      status.edit_ok    = edit_ok;
      status.count_zero = count_ff == '0;
      status.shift_more = shift_more;
      status.scan_more  = scan_more;
      status.pend       = pend_ff;
      status.hit        = hit;
      status.rsp_free   = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("route count above table depth");

   a_shift_in_range: assert property (@(posedge clock) disable iff (reset)
      shift_write |-> (ptr_minus < count_ff))
      else $error("shift writes beyond the last route");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> $stable(rsp_item_ff))
      else $error("held result overwritten");

endmodule
